/* src/serial_command_pwm_servo_control_core_defines.svh */
// Assertion macros for the serial command PWM and servo control core.
// Used by the top level; expects clk and rst_n in the including scope.
`ifndef SERIAL_COMMAND_PWM_SERVO_CONTROL_CORE_DEFINES_SVH
`define SERIAL_COMMAND_PWM_SERVO_CONTROL_CORE_DEFINES_SVH

// When ante holds at a clock edge, cons must hold at the same edge.
`define SCPSC_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// cond must never hold at a clock edge out of reset.
`define SCPSC_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

/* src/scpsc_pkg.sv */
// Shared constants, types and the constant-divide helper for the
// serial command PWM and servo control core. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package scpsc_pkg;

    localparam int LINE_CHARS  = 31;
    localparam int LEN_W       = $clog2(LINE_CHARS + 1);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Input item function codes.
    localparam logic [1:0] FUNC_BYTE   = 2'd0;
    localparam logic [1:0] FUNC_TICK   = 2'd1;
    localparam logic [1:0] FUNC_SAMPLE = 2'd2;

    // Command kinds produced by the front end.
    localparam logic [2:0] KIND_NOP    = 3'd0;
    localparam logic [2:0] KIND_LF     = 3'd1;
    localparam logic [2:0] KIND_NUL    = 3'd2;
    localparam logic [2:0] KIND_CHAR   = 3'd3;
    localparam logic [2:0] KIND_TICK   = 3'd4;
    localparam logic [2:0] KIND_SAMPLE = 3'd5;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;

    // Reply codes.
    localparam logic [2:0] REP_NONE  = 3'd0;
    localparam logic [2:0] REP_AUTO  = 3'd1;
    localparam logic [2:0] REP_POT   = 3'd2;
    localparam logic [2:0] REP_DUTY  = 3'd3;
    localparam logic [2:0] REP_SERVO = 3'd4;
    localparam logic [2:0] REP_ERROR = 3'd5;

    // Scaling applied in the output stage.
    localparam logic [1:0] SCL_DIRECT  = 2'd0;
    localparam logic [1:0] SCL_DIV255  = 2'd1;
    localparam logic [1:0] SCL_DIV1023 = 2'd2;

    typedef struct packed {
        logic [2:0] kind;
        logic [9:0] data;
    } cmd_t;

    typedef struct packed {
        logic        valid;
        cmd_t        cmd;
    } push_t;

    typedef struct packed {
        logic        led_write;
        logic [17:0] led_num;
        logic [1:0]  led_scl;
        logic        servo_write;
        logic [17:0] servo_num;
        logic [1:0]  servo_scl;
        logic [2:0]  reply;
    } exec_t;

    // Divide by 255 or 1023 using 2^k - 1 = divisor: the quotient estimate
    // n >> k leaves a remainder below twice the divisor, so one correction
    // step gives the exact floor.
    function automatic logic [7:0] scale_div(input logic [17:0] n, input logic [1:0] scl);
        logic [9:0]  q_hi;
        logic [10:0] r_hi;
        logic [7:0]  q_lo;
        logic [10:0] r_lo;
        logic [7:0]  res;
        q_hi = n[17:8];
        r_hi = {3'b000, n[7:0]} + {1'b0, q_hi};
        q_lo = n[17:10];
        r_lo = {1'b0, n[9:0]} + {3'b000, q_lo};
        case (scl)
            SCL_DIV255:  res = q_hi[7:0] + {7'd0, (r_hi >= 11'd255)};
            SCL_DIV1023: res = q_lo + {7'd0, (r_lo >= 11'd1023)};
            default:     res = n[7:0];
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

/* src/scpsc_if.sv */
// Valid/ready stream interfaces for the input items and the result items
// of the serial command PWM and servo control core. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface scpsc_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] rx_byte;
    logic [9:0] pot_sample;

    modport source (output valid, func, rx_byte, pot_sample, input ready);
    modport sink (input valid, func, rx_byte, pot_sample, output ready);
endinterface

interface scpsc_result_if;
    logic       valid;
    logic       ready;
    logic       led_write;
    logic [7:0] led_duty;
    logic       servo_write;
    logic [7:0] servo_angle;
    logic [2:0] reply;

    modport source (output valid, led_write, led_duty, servo_write, servo_angle, reply,
                    input ready);
    modport sink (input valid, led_write, led_duty, servo_write, servo_angle, reply,
                  output ready);
endinterface

`default_nettype wire

/* src/scpsc_front.sv */
// Front end: accepts input items and sorts them into command kinds.
// Depends on scpsc_pkg and scpsc_item_if.
`timescale 1ns / 1ps
`default_nettype none

module scpsc_front (
    scpsc_item_if.sink     item,
    input  wire logic      q_full,
    output scpsc_pkg::push_t push
);

    scpsc_pkg::cmd_t cmd;

    always_comb
    begin
        cmd.data = {2'b00, item.rx_byte};
        case (item.func)
            scpsc_pkg::FUNC_BYTE:
            begin
                // A carriage return never reaches the line: it is queued as a no-op command and still yields a result.
                if (item.rx_byte == scpsc_pkg::CH_LF)
                begin
                    cmd.kind = scpsc_pkg::KIND_LF;
                end
                else if (item.rx_byte == scpsc_pkg::CH_CR)
                begin
                    cmd.kind = scpsc_pkg::KIND_NOP;
                end
                else if (item.rx_byte == scpsc_pkg::CH_NUL)
                begin
                    cmd.kind = scpsc_pkg::KIND_NUL;
                end
                else
                begin
                    cmd.kind = scpsc_pkg::KIND_CHAR;
                end
            end
            scpsc_pkg::FUNC_TICK:
            begin
                cmd.kind = scpsc_pkg::KIND_TICK;
            end
            scpsc_pkg::FUNC_SAMPLE:
            begin
                cmd.kind = scpsc_pkg::KIND_SAMPLE;
                cmd.data = item.pot_sample;
            end
            default:
            begin
                cmd.kind = scpsc_pkg::KIND_NOP;
            end
        endcase
    end

    assign item.ready = !q_full;
    assign push.valid = item.valid && !q_full;
    assign push.cmd   = cmd;

endmodule

`default_nettype wire

/* src/scpsc_queue.sv */
// Short command queue between the front end and the back end.
// Depends on scpsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scpsc_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire scpsc_pkg::push_t push,
    output logic                  full,
    output logic                  pop_valid,
    output scpsc_pkg::cmd_t       pop_cmd,
    input  wire logic             pop
);

    scpsc_pkg::cmd_t                  mem_reg [scpsc_pkg::QUEUE_DEPTH];
    logic [scpsc_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [scpsc_pkg::QPTR_W-1:0]     wr_ptr_next;
    logic [scpsc_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [scpsc_pkg::QPTR_W-1:0]     rd_ptr_next;
    logic [scpsc_pkg::QCNT_W-1:0]     count_reg;
    logic [scpsc_pkg::QCNT_W-1:0]     count_next;
    logic                             do_push;
    logic                             do_pop;

    assign full      = (count_reg == scpsc_pkg::QCNT_W'(scpsc_pkg::QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_cmd   = mem_reg[rd_ptr_reg];
    assign do_push   = push.valid && !full;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push.cmd;
        end
    end

endmodule

`default_nettype wire

/* src/scpsc_back.sv */
// Back end: line parser, mode and sweep state, then the scaling stage and
// the output register. Depends on scpsc_pkg and scpsc_result_if.
`timescale 1ns / 1ps
`default_nettype none

module scpsc_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            q_valid,
    input  wire scpsc_pkg::cmd_t q_cmd,
    output logic                 q_pop,
    scpsc_result_if.source       result
);

    localparam logic [2:0] CLS_EMPTY = 3'd0;
    localparam logic [2:0] CLS_AUTO  = 3'd1;
    localparam logic [2:0] CLS_POT   = 3'd2;
    localparam logic [2:0] CLS_D     = 3'd3;
    localparam logic [2:0] CLS_S     = 3'd4;
    localparam logic [2:0] CLS_DNUM  = 3'd5;
    localparam logic [2:0] CLS_SNUM  = 3'd6;
    localparam logic [2:0] CLS_BAD   = 3'd7;

    localparam logic [1:0] PH_SPACE = 2'd0;
    localparam logic [1:0] PH_SIGN  = 2'd1;
    localparam logic [1:0] PH_DIGIT = 2'd2;
    localparam logic [1:0] PH_DONE  = 2'd3;

    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_U     = 8'h55;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [8:0] NUM_SAT = 9'd256;

    logic                          auto_mode_reg;
    logic                          auto_mode_next;
    logic [7:0]                    sweep_level_reg;
    logic [7:0]                    sweep_level_next;
    logic                          sweep_rising_reg;
    logic                          sweep_rising_next;
    logic [scpsc_pkg::LEN_W-1:0]   line_length_reg;
    logic [scpsc_pkg::LEN_W-1:0]   line_length_next;
    logic [2:0]                    line_class_reg;
    logic [2:0]                    line_class_next;
    logic [1:0]                    number_phase_reg;
    logic [1:0]                    number_phase_next;
    logic                          number_negative_reg;
    logic                          number_negative_next;
    logic [8:0]                    number_value_reg;
    logic [8:0]                    number_value_next;
    logic                          string_ended_reg;
    logic                          string_ended_next;

    logic                          s1_valid_reg;
    scpsc_pkg::exec_t              s1_reg;
    scpsc_pkg::exec_t              s1_next;
    logic                          out_valid_reg;
    logic                          out_adv;
    logic                          s1_adv;

    logic                          out_led_write_reg;
    logic [7:0]                    out_led_duty_reg;
    logic                          out_servo_write_reg;
    logic [7:0]                    out_servo_angle_reg;
    logic [2:0]                    out_reply_reg;

    // A line that ends here keeps only complete commands.
    function automatic logic [2:0] finalize(input logic [2:0] cls,
                                            input logic [scpsc_pkg::LEN_W-1:0] len);
        logic [2:0] res;
        res = cls;
        if (cls == CLS_AUTO && len != scpsc_pkg::LEN_W'(4))
        begin
            res = CLS_BAD;
        end
        else if (cls == CLS_POT && len != scpsc_pkg::LEN_W'(3))
        begin
            res = CLS_BAD;
        end
        else if (cls == CLS_EMPTY || cls == CLS_D || cls == CLS_S)
        begin
            res = CLS_BAD;
        end
        return res;
    endfunction

    function automatic logic [7:0] clamp_num(input logic neg, input logic [8:0] val,
                                             input logic [7:0] limit);
        logic [7:0] res;
        if (neg)
        begin
            res = 8'd0;
        end
        else if (val > {1'b0, limit})
        begin
            res = limit;
        end
        else
        begin
            res = val[7:0];
        end
        return res;
    endfunction

    assign out_adv = !out_valid_reg || result.ready;
    assign s1_adv  = !s1_valid_reg || out_adv;
    assign q_pop   = q_valid && s1_adv;

    always_comb
    begin
        logic [7:0]  c;
        logic [9:0]  x;
        logic [2:0]  cls;
        logic        digit;
        logic        space;
        logic [11:0] acc;
        logic        match_auto;
        logic        match_pot;

        auto_mode_next       = auto_mode_reg;
        sweep_level_next     = sweep_level_reg;
        sweep_rising_next    = sweep_rising_reg;
        line_length_next     = line_length_reg;
        line_class_next      = line_class_reg;
        number_phase_next    = number_phase_reg;
        number_negative_next = number_negative_reg;
        number_value_next    = number_value_reg;
        string_ended_next    = string_ended_reg;

        s1_next           = '0;
        s1_next.led_scl   = scpsc_pkg::SCL_DIRECT;
        s1_next.servo_scl = scpsc_pkg::SCL_DIRECT;
        s1_next.reply     = scpsc_pkg::REP_NONE;

        c     = q_cmd.data[7:0];
        x     = q_cmd.data;
        cls   = string_ended_reg ? line_class_reg : finalize(line_class_reg, line_length_reg);
        digit = (c inside {[8'h30:8'h39]});
        space = (c == CH_SPACE) || (c inside {[8'h09:8'h0D]});
        acc   = ({3'b000, number_value_reg} << 3) + ({3'b000, number_value_reg} << 1)
                + {8'd0, c[3:0]};
        match_auto = (line_length_reg == scpsc_pkg::LEN_W'(0) && c == CH_A)
                  || (line_length_reg == scpsc_pkg::LEN_W'(1) && c == CH_U)
                  || (line_length_reg == scpsc_pkg::LEN_W'(2) && c == CH_T)
                  || (line_length_reg == scpsc_pkg::LEN_W'(3) && c == CH_O);
        match_pot  = (line_length_reg == scpsc_pkg::LEN_W'(0) && c == CH_P)
                  || (line_length_reg == scpsc_pkg::LEN_W'(1) && c == CH_O)
                  || (line_length_reg == scpsc_pkg::LEN_W'(2) && c == CH_T);

        if (q_pop)
        begin
            case (q_cmd.kind)
                scpsc_pkg::KIND_LF:
                begin
                    case (cls)
                        CLS_AUTO:
                        begin
                            auto_mode_next = 1'b1;
                            s1_next.reply  = scpsc_pkg::REP_AUTO;
                        end
                        CLS_POT:
                        begin
                            auto_mode_next = 1'b0;
                            s1_next.reply  = scpsc_pkg::REP_POT;
                        end
                        CLS_DNUM:
                        begin
                            auto_mode_next    = 1'b0;
                            s1_next.led_write = 1'b1;
                            s1_next.led_num   = {10'd0, clamp_num(number_negative_reg,
                                                    number_value_reg, 8'd255)};
                            s1_next.reply     = scpsc_pkg::REP_DUTY;
                        end
                        CLS_SNUM:
                        begin
                            auto_mode_next      = 1'b0;
                            s1_next.servo_write = 1'b1;
                            s1_next.servo_num   = {10'd0, clamp_num(number_negative_reg,
                                                      number_value_reg, 8'd180)};
                            s1_next.reply       = scpsc_pkg::REP_SERVO;
                        end
                        default:
                        begin
                            s1_next.reply = scpsc_pkg::REP_ERROR;
                        end
                    endcase
                    line_length_next     = '0;
                    line_class_next      = CLS_EMPTY;
                    number_phase_next    = PH_SPACE;
                    number_negative_next = 1'b0;
                    number_value_next    = '0;
                    string_ended_next    = 1'b0;
                end
                scpsc_pkg::KIND_NUL:
                begin
                    if (line_length_reg < scpsc_pkg::LEN_W'(scpsc_pkg::LINE_CHARS))
                    begin
                        if (!string_ended_reg)
                        begin
                            string_ended_next = 1'b1;
                            line_class_next   = cls;
                        end
                        line_length_next = line_length_reg + 1'b1;
                    end
                end
                scpsc_pkg::KIND_CHAR:
                begin
                    if (line_length_reg < scpsc_pkg::LEN_W'(scpsc_pkg::LINE_CHARS))
                    begin
                        if (!string_ended_reg)
                        begin
                            case (line_class_reg)
                                CLS_EMPTY:
                                begin
                                    if (c == CH_A)
                                    begin
                                        line_class_next = CLS_AUTO;
                                    end
                                    else if (c == CH_P)
                                    begin
                                        line_class_next = CLS_POT;
                                    end
                                    else if (c == CH_D)
                                    begin
                                        line_class_next = CLS_D;
                                    end
                                    else if (c == CH_S)
                                    begin
                                        line_class_next = CLS_S;
                                    end
                                    else
                                    begin
                                        line_class_next = CLS_BAD;
                                    end
                                end
                                CLS_AUTO:
                                begin
                                    if (!match_auto)
                                    begin
                                        line_class_next = CLS_BAD;
                                    end
                                end
                                CLS_POT:
                                begin
                                    if (!match_pot)
                                    begin
                                        line_class_next = CLS_BAD;
                                    end
                                end
                                CLS_D:
                                begin
                                    line_class_next = (c == CH_COLON) ? CLS_DNUM : CLS_BAD;
                                end
                                CLS_S:
                                begin
                                    line_class_next = (c == CH_COLON) ? CLS_SNUM : CLS_BAD;
                                end
                                CLS_DNUM, CLS_SNUM:
                                begin
                                    case (number_phase_reg)
                                        PH_SPACE:
                                        begin
                                            if (space)
                                            begin
                                                number_phase_next = PH_SPACE;
                                            end
                                            else if (c == CH_PLUS || c == CH_MINUS)
                                            begin
                                                number_negative_next = (c == CH_MINUS);
                                                number_phase_next    = PH_SIGN;
                                            end
                                            else if (digit)
                                            begin
                                                number_value_next = {5'd0, c[3:0]};
                                                number_phase_next = PH_DIGIT;
                                            end
                                            else
                                            begin
                                                number_phase_next = PH_DONE;
                                            end
                                        end
                                        PH_SIGN, PH_DIGIT:
                                        begin
                                            if (digit)
                                            begin
                                                // The magnitude saturates just past the
                                                // largest clamp limit.
                                                number_value_next = (acc > {3'b000, NUM_SAT})
                                                                  ? NUM_SAT : acc[8:0];
                                                number_phase_next = PH_DIGIT;
                                            end
                                            else
                                            begin
                                                number_phase_next = PH_DONE;
                                            end
                                        end
                                        default:
                                        begin
                                            number_phase_next = number_phase_reg;
                                        end
                                    endcase
                                end
                                default:
                                begin
                                    line_class_next = line_class_reg;
                                end
                            endcase
                        end
                        line_length_next = line_length_reg + 1'b1;
                    end
                end
                scpsc_pkg::KIND_TICK:
                begin
                    if (auto_mode_reg)
                    begin
                        if (sweep_rising_reg)
                        begin
                            if (sweep_level_reg >= 8'd253)
                            begin
                                sweep_level_next  = 8'd255;
                                sweep_rising_next = 1'b0;
                            end
                            else
                            begin
                                sweep_level_next = sweep_level_reg + 8'd2;
                            end
                        end
                        else
                        begin
                            if (sweep_level_reg <= 8'd2)
                            begin
                                sweep_level_next  = 8'd0;
                                sweep_rising_next = 1'b1;
                            end
                            else
                            begin
                                sweep_level_next = sweep_level_reg - 8'd2;
                            end
                        end
                        s1_next.led_write   = 1'b1;
                        s1_next.led_num     = {10'd0, sweep_level_next};
                        s1_next.servo_write = 1'b1;
                        s1_next.servo_num   = {10'd0, sweep_level_next} * 18'd180;
                        s1_next.servo_scl   = scpsc_pkg::SCL_DIV255;
                    end
                end
                scpsc_pkg::KIND_SAMPLE:
                begin
                    if (!auto_mode_reg)
                    begin
                        s1_next.led_write   = 1'b1;
                        s1_next.led_num     = {8'd0, x} * 18'd255;
                        s1_next.led_scl     = scpsc_pkg::SCL_DIV1023;
                        s1_next.servo_write = 1'b1;
                        s1_next.servo_num   = {8'd0, x} * 18'd180;
                        s1_next.servo_scl   = scpsc_pkg::SCL_DIV1023;
                    end
                end
                default:
                begin
                    s1_next.reply = scpsc_pkg::REP_NONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            auto_mode_reg       <= 1'b1;
            sweep_level_reg     <= 8'd0;
            sweep_rising_reg    <= 1'b1;
            line_length_reg     <= '0;
            line_class_reg      <= CLS_EMPTY;
            number_phase_reg    <= PH_SPACE;
            number_negative_reg <= 1'b0;
            number_value_reg    <= '0;
            string_ended_reg    <= 1'b0;
            s1_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            auto_mode_reg       <= auto_mode_next;
            sweep_level_reg     <= sweep_level_next;
            sweep_rising_reg    <= sweep_rising_next;
            line_length_reg     <= line_length_next;
            line_class_reg      <= line_class_next;
            number_phase_reg    <= number_phase_next;
            number_negative_reg <= number_negative_next;
            number_value_reg    <= number_value_next;
            string_ended_reg    <= string_ended_next;
            if (s1_adv)
            begin
                s1_valid_reg <= q_pop;
            end
            if (out_adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s1_reg <= s1_next;
        end
        if (out_adv)
        begin
            out_led_write_reg   <= s1_reg.led_write;
            out_led_duty_reg    <= scpsc_pkg::scale_div(s1_reg.led_num, s1_reg.led_scl);
            out_servo_write_reg <= s1_reg.servo_write;
            out_servo_angle_reg <= scpsc_pkg::scale_div(s1_reg.servo_num, s1_reg.servo_scl);
            out_reply_reg       <= s1_reg.reply;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.led_write   = out_led_write_reg;
    assign result.led_duty    = out_led_duty_reg;
    assign result.servo_write = out_servo_write_reg;
    assign result.servo_angle = out_servo_angle_reg;
    assign result.reply       = out_reply_reg;

endmodule

`default_nettype wire

/* src/serial_command_pwm_servo_control_core.sv */
// Top level of the serial command PWM and servo control core.
// Depends on scpsc_pkg, scpsc_if, scpsc_front, scpsc_queue, scpsc_back and the defines header.
`timescale 1ns / 1ps
`default_nettype none

`include "serial_command_pwm_servo_control_core_defines.svh"

// The core takes one item per clock while item.ready is high and returns exactly one result
// for each item, in order. A received byte, a sweep tick or a potentiometer sample is
// transferred on item; the front end sorts it into a command and places it in a four-entry
// queue, and the back end applies it to the line parser, mode and sweep state, scales the
// LED and servo values in a second stage and holds the result in an output register until
// it is transferred. With result always ready, the state update in the back end sets the
// sustained rate of one item per cycle. When result stalls, the queue and the two back-end
// stages absorb up to six items before item.ready drops.
module serial_command_pwm_servo_control_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    scpsc_item_if.sink       item,
    scpsc_result_if.source   result
);

    scpsc_pkg::push_t  push;
    scpsc_pkg::cmd_t   q_cmd;
    logic              q_full;
    logic              q_valid;
    logic              q_pop;

    scpsc_front u_front (
        .item   (item),
        .q_full (q_full),
        .push   (push)
    );

    scpsc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (q_full),
        .pop_valid (q_valid),
        .pop_cmd   (q_cmd),
        .pop       (q_pop)
    );

    scpsc_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .q_pop   (q_pop),
        .result  (result)
    );

    `SCPSC_ASSERT_IMPLY(a_led_idle_zero, result.valid && !result.led_write, result.led_duty == 8'd0, "LED duty not zero without a write")
    `SCPSC_ASSERT_IMPLY(a_servo_range, result.valid && result.servo_write, result.servo_angle <= 8'd180, "servo angle beyond 180 degrees")
    `SCPSC_ASSERT_IMPLY(a_duty_reply, result.valid && result.reply == scpsc_pkg::REP_DUTY, result.led_write && !result.servo_write, "duty reply without an LED-only write")
    `SCPSC_ASSERT_NEVER(a_reply_code, result.valid && result.reply > scpsc_pkg::REP_ERROR, "undefined reply code")

endmodule

`default_nettype wire
